// ===== design/bab_pkg.sv =====
// shared constants, types and angle table function for the bearing block
`timescale 1ns / 1ps
`default_nettype none
package bab_pkg;

  // default sizes handed to the top level
  localparam int COORD_BITS_DEF    = 24;
  localparam int CORDIC_STAGES_DEF = 20;

  // vector lanes hold the scaled doubled difference, angle lane degrees Q.24
  localparam int XW      = 64;
  localparam int ZW      = 34;
  localparam int RW      = ZW - 15;
  localparam int ANGLE_W = 17;
  localparam int SCALE_TOP = 58;

  localparam int FULL_TURN = 92160;
  localparam logic [63:0] DEG_Q24_PER_RAD = 64'd961263669;
  localparam logic [63:0] FORTY_FIVE_Q24  = 64'd754974720;
  localparam logic [63:0] HALF_TURN_Q24   = 64'd3019898880;

  // one item travelling through the rotation stages
  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } bab_vec_t;

  // restoring long division, evaluated at elaboration only
  function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) in degrees Q.24 from a truncated series in Q.60 radians
  function automatic logic [63:0] stage_angle(input int unsigned i);
    logic signed [63:0] s;
    logic [63:0]        t;
    logic [63:0]        p;
    int unsigned        e;
    logic               done;
    s = '0;
    done = 1'b0;
    p = FORTY_FIVE_Q24;
    if (i != 0) begin
      for (int unsigned k = 0; k < 64; k++) begin
        e = i * (2 * k + 1);
        if (e > 60) done = 1'b1;
        if (!done) begin
          t = div_floor(64'd1 << (60 - e), 64'(2 * k + 1));
          if (k % 2 == 1) s = s - $signed(t);
          else s = s + $signed(t);
        end
      end
      if (s < 0) s = '0;
      p = (((64'(s) >> 28) * DEG_Q24_PER_RAD) + (64'd1 << 31)) >> 32;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/bab_front.sv =====
// front end: shape centres, then difference vector folded into the right half-plane
`timescale 1ns / 1ps
`default_nettype none
module bab_front #(
  parameter int COORD_BITS = bab_pkg::COORD_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         en,
  input  wire                         in_valid,
  input  wire signed [COORD_BITS-1:0] first_x,
  input  wire signed [COORD_BITS-1:0] first_y,
  input  wire        [COORD_BITS-2:0] first_w,
  input  wire        [COORD_BITS-2:0] first_h,
  input  wire                         first_is_circle,
  input  wire signed [COORD_BITS-1:0] second_x,
  input  wire signed [COORD_BITS-1:0] second_y,
  input  wire        [COORD_BITS-2:0] second_w,
  input  wire        [COORD_BITS-2:0] second_h,
  input  wire                         second_is_circle,
  output logic                        vec_valid,
  output bab_pkg::bab_vec_t           vec
);

  localparam int CW = COORD_BITS + 2;
  localparam int DW = COORD_BITS + 3;
  localparam int XW = bab_pkg::XW;
  localparam int ZW = bab_pkg::ZW;
  localparam int SHIFT = bab_pkg::SCALE_TOP - COORD_BITS;

  logic signed [CW-1:0] c1x, c1y, c2x, c2y;
  logic signed [CW-1:0] c1x_next, c1y_next, c2x_next, c2y_next;
  logic                 ctr_valid;

  logic signed [DW-1:0] dx, ndx, dy, ndy, xi, yi;
  logic                 left;
  bab_pkg::bab_vec_t    vec_next;

  // doubled centre: 2*pos plus size for a rectangle
  function automatic logic signed [CW-1:0] centre2(
    input logic [COORD_BITS-1:0] pos,
    input logic [COORD_BITS-2:0] size,
    input logic                  circ
  );
    logic [CW-1:0] add;
    add = circ ? '0 : {3'b000, size};
    return $signed({pos[COORD_BITS-1], pos, 1'b0}) + $signed(add);
  endfunction

  always_comb begin
    c1x_next = centre2(first_x, first_w, first_is_circle);
    c1y_next = centre2(first_y, first_h, first_is_circle);
    c2x_next = centre2(second_x, second_w, second_is_circle);
    c2y_next = centre2(second_y, second_h, second_is_circle);
  end

  // centre registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_valid <= 1'b0;
    end else if (en) begin
      ctr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1x <= c1x_next;
      c1y <= c1y_next;
      c2x <= c2x_next;
      c2y <= c2y_next;
    end
  end

  // differences in both senses, pick the one with non-negative x
  always_comb begin
    dx   = DW'(c2x) - DW'(c1x);
    ndx  = DW'(c1x) - DW'(c2x);
    dy   = DW'(c2y) - DW'(c1y);
    ndy  = DW'(c1y) - DW'(c2y);
    left = dx[DW-1];
    xi   = left ? ndx : dx;
    yi   = left ? dy : ndy;
    vec_next.zero = (c1x == c2x) && (c1y == c2y);
    vec_next.x    = $signed({{(XW - DW){xi[DW-1]}}, xi}) <<< SHIFT;
    vec_next.y    = $signed({{(XW - DW){yi[DW-1]}}, yi}) <<< SHIFT;
    vec_next.z    = left ? $signed(ZW'(bab_pkg::HALF_TURN_Q24)) : '0;
  end

  // start vector register
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_valid <= 1'b0;
    end else if (en) begin
      vec_valid <= ctr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec <= vec_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/bab_cordic_stage.sv =====
// one vectoring rotation step with its pipeline register
`timescale 1ns / 1ps
`default_nettype none
module bab_cordic_stage #(
  parameter int STAGE = 0
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_valid,
  input  bab_pkg::bab_vec_t in_vec,
  output logic              out_valid,
  output bab_pkg::bab_vec_t out_vec
);

  localparam int ZW = bab_pkg::ZW;
  localparam logic signed [ZW-1:0] ANGLE = ZW'(bab_pkg::stage_angle(STAGE));

  logic signed [bab_pkg::XW-1:0] xs, ys;
  bab_pkg::bab_vec_t             vec_next;

  // rotate toward the x axis, accumulate the turned angle
  always_comb begin
    xs = in_vec.x >>> STAGE;
    ys = in_vec.y >>> STAGE;
    vec_next.zero = in_vec.zero;
    if (in_vec.y > 0) begin
      vec_next.x = in_vec.x + ys;
      vec_next.y = in_vec.y - xs;
      vec_next.z = in_vec.z + ANGLE;
    end else begin
      vec_next.x = in_vec.x - ys;
      vec_next.y = in_vec.y + xs;
      vec_next.z = in_vec.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec <= vec_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/bab_back.sv =====
// back end: round the angle to 1/256 degree, wrap into one turn, output register
`timescale 1ns / 1ps
`default_nettype none
module bab_back (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           en,
  input  wire                           out_en,
  input  wire                           in_valid,
  input  bab_pkg::bab_vec_t             in_vec,
  output logic                          rnd_valid,
  output logic                          out_valid,
  output logic [bab_pkg::ANGLE_W-1:0]   bearing_angle
);

  localparam int ZW = bab_pkg::ZW;
  localparam int RW = bab_pkg::RW;
  localparam int AW = bab_pkg::ANGLE_W;
  localparam logic signed [RW-1:0] TURN = RW'(bab_pkg::FULL_TURN);

  logic [ZW:0]          sum;
  logic signed [RW-1:0] rnd, rnd_next;
  logic                 rnd_zero;
  logic signed [RW-1:0] wrapped;
  logic [AW-1:0]        angle_next;

  // round half up, floor shift
  always_comb begin
    sum      = {in_vec.z[ZW-1], in_vec.z} + (ZW + 1)'(1 << 15);
    rnd_next = $signed(sum[ZW:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd      <= rnd_next;
      rnd_zero <= in_vec.zero;
    end
  end

  // wrap into one turn; coincident centres give zero
  always_comb begin
    if (rnd < 0) begin
      wrapped = rnd + TURN;
    end else if (rnd >= TURN) begin
      wrapped = rnd - TURN;
    end else begin
      wrapped = rnd;
    end
    angle_next = rnd_zero ? '0 : wrapped[AW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= rnd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      bearing_angle <= angle_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/bearing_angle_between_shapes.sv =====
// top level: bearing from one shape centre to another in 1/256 degree
// Screen-space bearing (y grows downward) from the centre of the first shape to the
// centre of the second, as atan2(-dy, dx) in [0, 360) degrees with 1/256 degree
// resolution; coincident centres give 0. A rectangle's centre is its corner plus half
// its size, a circle's centre is given directly. One item is taken every clock cycle
// while in_stall is low. Each item passes the centre register, the start vector register
// (centres and difference vector), one register per CORDIC rotation step, the round
// register and the output register, which takes the angle wrapped into one turn.
// A stalled output holds the whole pipeline only once the round stage is also occupied.
`timescale 1ns / 1ps
`default_nettype none
module bearing_angle_between_shapes #(
  parameter int CORDIC_STAGES = bab_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = bab_pkg::COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [COORD_BITS-1:0]  first_x,
  input  wire signed [COORD_BITS-1:0]  first_y,
  input  wire        [COORD_BITS-2:0]  first_w,
  input  wire        [COORD_BITS-2:0]  first_h,
  input  wire                          first_is_circle,
  input  wire signed [COORD_BITS-1:0]  second_x,
  input  wire signed [COORD_BITS-1:0]  second_y,
  input  wire        [COORD_BITS-2:0]  second_w,
  input  wire        [COORD_BITS-2:0]  second_h,
  input  wire                          second_is_circle,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [bab_pkg::ANGLE_W-1:0]  bearing_angle
);

  logic              out_en, pipe_en, rnd_valid;
  logic              vld [0:CORDIC_STAGES];
  bab_pkg::bab_vec_t vec [0:CORDIC_STAGES];

  // output register moves when empty or taken; the rest also moves into a free round stage
  always_comb begin
    out_en   = !out_valid || !out_stall;
    pipe_en  = out_en || !rnd_valid;
    in_stall = !pipe_en;
  end

  bab_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (pipe_en),
    .in_valid         (in_valid),
    .first_x          (first_x),
    .first_y          (first_y),
    .first_w          (first_w),
    .first_h          (first_h),
    .first_is_circle  (first_is_circle),
    .second_x         (second_x),
    .second_y         (second_y),
    .second_w         (second_w),
    .second_h         (second_h),
    .second_is_circle (second_is_circle),
    .vec_valid        (vld[0]),
    .vec              (vec[0])
  );

  // rotation steps, one register each
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    bab_cordic_stage #(
      .STAGE(i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .in_valid  (vld[i]),
      .in_vec    (vec[i]),
      .out_valid (vld[i+1]),
      .out_vec   (vec[i+1])
    );
  end

  bab_back u_back (
    .clk           (clk),
    .rst           (rst),
    .en            (pipe_en),
    .out_en        (out_en),
    .in_valid      (vld[CORDIC_STAGES]),
    .in_vec        (vec[CORDIC_STAGES]),
    .rnd_valid     (rnd_valid),
    .out_valid     (out_valid),
    .bearing_angle (bearing_angle)
  );

endmodule
`default_nettype wire
